[src/sio_pkg.sv]
package sio_pkg;

  localparam int NUM_DEVICES     = 11;
  localparam int NUM_GLOBAL_REGS = 48;
  localparam int DEV_DEPTH       = NUM_DEVICES * 256;
  localparam int MEM_DEPTH       = DEV_DEPTH + NUM_GLOBAL_REGS;
  localparam int AW              = $clog2(MEM_DEPTH);

  localparam logic [7:0] KEY_ON    = 8'h55;
  localparam logic [7:0] KEY_OFF   = 8'hAA;
  localparam logic [7:0] GPIO_MASK = 8'h83;
  localparam logic [7:0] LOCK_MASK = 8'h0F;
  localparam logic [7:0] G22_RST   = 8'h39;
  localparam logic [7:0] CHIP_RST  = 8'h03;
  localparam logic [7:0] ID_RTC    = 8'h30;
  localparam logic [7:0] ID_NOAPM  = 8'h02;

  localparam logic [9:0] PORT_IDX_A  = 10'h0EA;
  localparam logic [9:0] PORT_DATA_A = 10'h0EB;
  localparam logic [9:0] PORT_IDX_B  = 10'h0F9;
  localparam logic [9:0] PORT_IDX_C  = 10'h0FB;

  localparam logic [7:0] G_CTRL  = 8'h03;
  localparam logic [7:0] G_LDN   = 8'h07;
  localparam logic [7:0] G_ID    = 8'h20;
  localparam logic [7:0] G_REV   = 8'h21;
  localparam logic [7:0] G_PWR   = 8'h22;

  localparam logic [7:0] B_FDC  = 8'd0;
  localparam logic [7:0] B_IDE1 = 8'd1;
  localparam logic [7:0] B_IDE2 = 8'd2;
  localparam logic [7:0] B_LPT  = 8'd3;
  localparam logic [7:0] B_SER1 = 8'd4;
  localparam logic [7:0] B_SER2 = 8'd5;
  localparam logic [7:0] B_RTC  = 8'd6;
  localparam logic [7:0] B_KBD  = 8'd7;
  localparam logic [7:0] B_AUX  = 8'd8;
  localparam logic [7:0] B_ABUS = 8'd9;
  localparam logic [7:0] B_ACPI = 8'd10;

  localparam int RM_GPIO     = 0;
  localparam int RM_FDC      = 1;
  localparam int RM_LPT      = 2;
  localparam int RM_UART0    = 3;
  localparam int RM_UART1    = 4;
  localparam int RM_ABUS     = 5;
  localparam int RM_NVR_PRI  = 6;
  localparam int RM_NVR_SEC  = 7;
  localparam int RM_NVR_LOCK = 8;
  localparam int RM_AUXIO    = 9;
  localparam int RM_ACPI     = 10;
  localparam int RM_FDC_MODE = 11;

  localparam logic CFG_CHIP_ID = 1'b0;
  localparam logic CFG_APM     = 1'b1;

  typedef struct packed {
    logic       func;
    logic [9:0] port;
    logic [7:0] wdata;
  } req_t;

  typedef struct packed {
    logic       unl;
    logic       fks;
    logic [7:0] idx;
    logic [7:0] g7;
    logic [7:0] g22;
    logic [7:0] rtc63;
    logic [7:0] chip;
    logic       apm;
  } st_t;

  typedef struct packed {
    logic [7:0]  rd;
    logic        mode;
    logic [11:0] mask;
  } res_t;

  function automatic logic [7:0] rtc_dflt(logic [7:0] chip);
    return (chip == ID_RTC) ? 8'h70 : 8'h00;
  endfunction

  function automatic logic [7:0] mem_dflt(logic [AW-1:0] a);
    logic [7:0] bank;
    logic [7:0] r;
    logic [7:0] v;
    bank = 8'(a >> 8);
    r    = a[7:0];
    v    = 8'h00;
    if (32'(a) >= DEV_DEPTH) begin
      r = 8'(32'(a) - DEV_DEPTH);
      case (r)
        8'h03: v = 8'h03;
        8'h21: v = 8'h01;
        8'h24: v = 8'h04;
        8'h26: v = 8'hF0;
        8'h27: v = 8'h03;
        default: v = 8'h00;
      endcase
    end else begin
      case (bank)
        B_FDC: case (r)
          8'h30: v = 8'h01; 8'h60: v = 8'h03; 8'h61: v = 8'hF0; 8'h70: v = 8'h06;
          8'h74: v = 8'h02; 8'hF0: v = 8'h0E; 8'hF2: v = 8'hFF; default: v = 8'h00;
        endcase
        B_IDE1: case (r)
          8'h60: v = 8'h01; 8'h61: v = 8'hF0; 8'h62: v = 8'h03; 8'h63: v = 8'hF6;
          8'h70: v = 8'h0E; 8'hF0: v = 8'h0C; default: v = 8'h00;
        endcase
        B_IDE2: case (r)
          8'h60: v = 8'h01; 8'h61: v = 8'h70; 8'h62: v = 8'h03; 8'h63: v = 8'h76;
          8'h70: v = 8'h0F; default: v = 8'h00;
        endcase
        B_LPT: case (r)
          8'h30: v = 8'h01; 8'h60: v = 8'h03; 8'h61: v = 8'h78; 8'h70: v = 8'h07;
          8'h74: v = 8'h04; 8'hF0: v = 8'h3C; default: v = 8'h00;
        endcase
        B_SER1: case (r)
          8'h30: v = 8'h01; 8'h60: v = 8'h03; 8'h61: v = 8'hF8; 8'h70: v = 8'h04;
          8'hF0: v = 8'h03; default: v = 8'h00;
        endcase
        B_SER2: case (r)
          8'h30: v = 8'h01; 8'h60: v = 8'h02; 8'h61: v = 8'hF8; 8'h70: v = 8'h03;
          8'h74: v = 8'h04; 8'hF1: v = 8'h02; 8'hF2: v = 8'h03; default: v = 8'h00;
        endcase
        B_RTC: case (r)
          8'h30: v = 8'h01; 8'hF4: v = 8'h03; default: v = 8'h00;
        endcase
        B_KBD: case (r)
          8'h30: v = 8'h01; 8'h61: v = 8'h60; 8'h70: v = 8'h01; default: v = 8'h00;
        endcase
        default: v = 8'h00;
      endcase
    end
    return v;
  endfunction

endpackage

[src/superio_config_register_port_unit.sv]
// a request is taken into stage s1; its result is registered in the output once s1 can fire
// one request per cycle unless the output stalls, read-modify-write on the register memory
// reset: control state clears at once, then a clearing pass writes the register
// defaults into the memory, one entry a cycle over all 2864 entries; no request is taken meanwhile
module superio_config_register_port_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [9:0]  port_addr_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic        config_mode_o,
  output logic [11:0] remap_mask_o
);
  import sio_pkg::*;

  logic          clr_q, clr_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          s1_vld_q;
  req_t          s1_req_q;
  logic [AW-1:0] s1_addr_q;
  logic          byp_vld_q;
  logic [7:0]    byp_data_q;
  st_t           st_q, st_d, st_n;
  logic          out_vld_q;
  res_t          out_q;

  logic          adv, fire, accept, cfg_we;
  logic [AW-1:0] raddr, new_addr, waddr;
  logic [7:0]    rdata, old, wdata;
  logic          we;
  st_t           ex_st;
  res_t          ex_res;
  logic          ex_we;
  logic [7:0]    ex_wdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign adv         = !out_vld_q || out_ready_i;
  assign fire        = s1_vld_q && adv;
  assign in_ready_o  = !clr_q && (!s1_vld_q || adv);
  assign accept      = in_valid_i && in_ready_o;

  assign old = byp_vld_q ? byp_data_q : rdata;

  sio_exec u_exec (
    .req_i       (s1_req_q),
    .st_i        (st_q),
    .old_i       (old),
    .st_o        (ex_st),
    .res_o       (ex_res),
    .mem_we_o    (ex_we),
    .mem_wdata_o (ex_wdata)
  );

  assign st_n = fire ? ex_st : st_q;

  always_comb begin
    if (32'(st_n.idx) < NUM_GLOBAL_REGS) begin
      new_addr = AW'(DEV_DEPTH + 32'(st_n.idx));
    end else begin
      new_addr = AW'({st_n.g7[3:0], st_n.idx});
    end
    raddr = (s1_vld_q && !adv) ? s1_addr_q : new_addr;
    if (clr_q) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = mem_dflt(clr_cnt_q);
    end else begin
      we    = fire && ex_we;
      waddr = s1_addr_q;
      wdata = ex_wdata;
    end
  end

  sio_ram #(.Width(8), .Depth(MEM_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    st_d      = st_n;
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (32'(clr_cnt_q) == MEM_DEPTH - 1) clr_d = 1'b0;
    end
    if (cfg_we) begin
      case (cfg_index_i)
        CFG_CHIP_ID: begin
          st_d.chip  = cfg_data_i;
          st_d.rtc63 = rtc_dflt(cfg_data_i);
        end
        CFG_APM: st_d.apm = cfg_data_i[0];
        default: st_d = st_n;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      s1_vld_q  <= 1'b0;
      byp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '{unl: 1'b0, fks: 1'b0, idx: 8'h00, g7: 8'h00, g22: G22_RST,
                     rtc63: rtc_dflt(CHIP_RST), chip: CHIP_RST, apm: 1'b0};
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
      st_q      <= st_d;
      byp_vld_q <= we && !clr_q && (waddr == raddr);
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (fire) begin
        s1_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= wdata;
    if (accept) begin
      s1_req_q  <= '{func: func_i, port: port_addr_i, wdata: write_data_i};
      s1_addr_q <= new_addr;
    end
    if (fire) begin
      out_q <= ex_res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign read_data_o   = out_q.rd;
  assign config_mode_o = out_q.mode;
  assign remap_mask_o  = out_q.mask;

  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s1_vld_q && !in_ready_o) else $error("request taken during clearing pass");

  a_read_no_remap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !s1_req_q.func |=> out_q.mask == '0) else $error("remap reported on a read");

  a_unlock_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(st_q.unl) |-> $past(st_q.fks)) else $error("unlock without first key");

  a_mode_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_q.mode == st_q.unl) else $error("mode flag differs from state");

endmodule

[src/sio_ram.sv]
module sio_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[src/sio_exec.sv]
module sio_exec (
  input  sio_pkg::req_t   req_i,
  input  sio_pkg::st_t    st_i,
  input  logic [7:0]      old_i,
  output sio_pkg::st_t    st_o,
  output sio_pkg::res_t   res_o,
  output logic            mem_we_o,
  output logic [7:0]      mem_wdata_o
);
  import sio_pkg::*;

  logic       is_idx;
  logic       blk;
  logic       is63;
  logic [7:0] val;
  logic [7:0] idx;
  logic [7:0] bank;
  logic [7:0] prev;
  logic [7:0] keep;
  logic [7:0] vx;
  logic       reg_io;

  always_comb begin
    st_o        = st_i;
    res_o       = '0;
    mem_we_o    = 1'b0;
    mem_wdata_o = old_i;
    val         = req_i.wdata;
    idx         = st_i.idx;
    bank        = st_i.g7;
    blk         = 1'b0;
    is63        = 1'b0;
    prev        = old_i;
    keep        = 8'h00;
    vx          = 8'h00;
    reg_io      = (idx == 8'h30) || (idx == 8'h60) || (idx == 8'h61) || (idx == 8'h70);

    is_idx = ~req_i.port[0];
    if (req_i.port == PORT_IDX_A || req_i.port == PORT_IDX_B || req_i.port == PORT_IDX_C) begin
      is_idx = 1'b1;
    end else if (req_i.port == PORT_DATA_A) begin
      is_idx = 1'b0;
    end

    if (req_i.func) begin
      if (is_idx) begin
        if (val == KEY_ON && !st_i.unl) begin
          if (st_i.fks) begin
            st_o.unl = 1'b1;
            st_o.fks = 1'b0;
          end else begin
            st_o.fks = 1'b1;
          end
        end else if (st_i.unl) begin
          if (val == KEY_OFF) begin
            st_o.unl = 1'b0;
          end else begin
            st_o.idx = val;
          end
        end else begin
          st_o.fks = 1'b0;
        end
      end else if (st_i.unl) begin
        if (32'(idx) < NUM_GLOBAL_REGS) begin
          if (idx == G_ID || idx == G_REV) begin
            mem_we_o = 1'b0;
          end else if (idx == G_LDN) begin
            st_o.g7 = val;
          end else if (idx == G_PWR) begin
            vx = val ^ st_i.g22;
            st_o.g22 = val;
            res_o.mask[RM_FDC]   = vx[0];
            res_o.mask[RM_LPT]   = vx[3];
            res_o.mask[RM_UART0] = vx[4];
            res_o.mask[RM_UART1] = vx[5];
            res_o.mask[RM_ABUS]  = vx[6] && (st_i.chip != ID_NOAPM);
          end else if (idx == G_CTRL) begin
            vx = val ^ old_i;
            mem_we_o = 1'b1;
            mem_wdata_o = val & GPIO_MASK;
            res_o.mask[RM_GPIO] = |(vx & GPIO_MASK);
          end else begin
            mem_we_o = 1'b1;
            mem_wdata_o = val;
          end
        end else begin
          blk = (32'(bank) >= NUM_DEVICES)
              || (idx[7:4] == 4'h7 && bank < B_SER1)
              || bank == B_IDE1 || bank == B_IDE2 || bank == B_KBD
              || (bank == B_RTC && st_i.chip != ID_RTC)
              || (bank == B_ABUS && !st_i.apm && st_i.chip == ID_NOAPM)
              || (bank == B_ACPI && !st_i.apm);
          if (!blk) begin
            is63 = (bank == B_RTC) && (idx == 8'h63);
            prev = is63 ? st_i.rtc63 : old_i;
            if (bank == B_RTC && idx == 8'hF0) begin
              keep = old_i & LOCK_MASK;
            end
            vx = val ^ prev;
            if (is63) begin
              st_o.rtc63 = val | keep;
            end else begin
              mem_we_o = 1'b1;
              mem_wdata_o = val | keep;
            end
            case (bank)
              B_FDC: begin
                if (idx == 8'h30 || idx == 8'h60 || idx == 8'h61) begin
                  if (idx == 8'h30 && val[0]) st_o.g22[0] = 1'b1;
                  res_o.mask[RM_FDC] = |vx;
                end else if ((idx == 8'hF0 && |(vx & 8'h11)) || (idx == 8'hF1 && |(vx & 8'h0C))
                             || (idx == 8'hF2 && |vx)
                             || (idx >= 8'hF4 && idx <= 8'hF7 && |(vx & 8'h18))) begin
                  res_o.mask[RM_FDC_MODE] = 1'b1;
                end
              end
              B_LPT: begin
                if (reg_io) begin
                  if (idx == 8'h30 && val[0]) st_o.g22[3] = 1'b1;
                  res_o.mask[RM_LPT] = |vx;
                end
              end
              B_SER1: begin
                if (reg_io) begin
                  if (idx == 8'h30 && val[0]) st_o.g22[4] = 1'b1;
                  res_o.mask[RM_UART0] = |vx;
                end
              end
              B_SER2: begin
                if (reg_io) begin
                  if (idx == 8'h30 && val[0]) st_o.g22[5] = 1'b1;
                  res_o.mask[RM_UART1] = |vx;
                end
              end
              B_ABUS: begin
                if (reg_io) begin
                  if (idx == 8'h30 && val[0]) st_o.g22[6] = 1'b1;
                  res_o.mask[RM_ABUS] = |vx;
                end
              end
              B_RTC: begin
                if (|vx) begin
                  if (idx == 8'h30) begin
                    res_o.mask[RM_NVR_PRI] = 1'b1;
                    res_o.mask[RM_NVR_SEC] = 1'b1;
                  end else if (idx == 8'h62 || idx == 8'h63) begin
                    res_o.mask[RM_NVR_SEC] = 1'b1;
                  end else if (idx == 8'hF0) begin
                    res_o.mask[RM_NVR_LOCK] = 1'b1;
                  end
                end
              end
              B_AUX: res_o.mask[RM_AUXIO] = reg_io && |vx;
              B_ACPI: res_o.mask[RM_ACPI] = (reg_io || (idx >= 8'h60 && idx <= 8'h63)) && |vx;
              default: res_o.mask = '0;
            endcase
          end
        end
      end
    end else begin
      res_o.rd = 8'hFF;
      if (st_i.unl) begin
        if (is_idx) begin
          res_o.rd = idx;
        end else if (32'(idx) < NUM_GLOBAL_REGS) begin
          case (idx)
            G_ID:    res_o.rd = st_i.chip;
            G_LDN:   res_o.rd = st_i.g7;
            G_PWR:   res_o.rd = st_i.g22;
            default: res_o.rd = old_i;
          endcase
        end else if (32'(bank) < NUM_DEVICES) begin
          res_o.rd = (bank == B_RTC && idx == 8'h63) ? st_i.rtc63 : old_i;
        end
      end
    end
    res_o.mode = st_o.unl;
  end

endmodule
